// File: rtl/ots_pkg.sv
package ots_pkg;

    localparam int MAX_ITEMS_DEF = 1024;
    localparam int QW            = 32;
    localparam int OUT_CW        = 11;
    localparam int RATIO_W       = 16;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEF_THR     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_EN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_RATIO = 2'd2;

    localparam logic [QW-1:0]      DEF_THR_RST     = 32'h0000_8000;
    localparam logic [RATIO_W-1:0] FLOOR_RATIO_RST = 16'h8000;
    localparam logic [QW-1:0]      Q_MAX           = 32'h7FFF_FFFF;
    localparam logic [QW-1:0]      Q_MIN           = 32'h8000_0000;

    typedef struct packed {
        logic          vld;
        logic [QW-1:0] score;
        logic          label;
    } t_item;

    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } t_step;

endpackage

// File: rtl/ots_cell.sv
module ots_cell
    import ots_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  t_item i_in,
    input  t_item i_right,
    output t_item o_pass,
    output t_item o_held
);

    t_item r_held, n_held;
    t_item r_pass, n_pass;

    // insert: keep the larger score, hand the smaller (or equal) one on; shift: take the right neighbour's item
    always_comb begin
        n_held = r_held;
        n_pass = '0;
        if (i_shift) begin
            n_held = i_right;
        end else if (i_in.vld) begin
            if (!r_held.vld) begin
                n_held = i_in;
            end else if ($signed(i_in.score) > $signed(r_held.score)) begin
                n_held = i_in;
                n_pass = r_held;
            end else begin
                n_pass = i_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_pass <= '0;
        end else begin
            r_held <= n_held;
            r_pass <= n_pass;
        end
    end

    assign o_pass = r_pass;
    assign o_held = r_held;

endmodule

// File: rtl/ots_sweep.sv
module ots_sweep
    import ots_pkg::*;
#(
    parameter int CW = $clog2(MAX_ITEMS_DEF + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_step              i_step,
    input  t_item              i_item,
    input  logic [CW-1:0]      i_idx,
    input  logic [CW-1:0]      i_pos,
    input  logic [QW-1:0]      i_def_thr,
    input  logic               i_floor_en,
    input  logic [RATIO_W-1:0] i_floor_ratio,
    output logic               o_valid,
    output logic [QW-1:0]      o_threshold,
    output logic [OUT_CW-1:0]  o_best_true_pos,
    output logic [OUT_CW-1:0]  o_best_pred_pos,
    output logic [OUT_CW-1:0]  o_actual_pos,
    output logic               o_floor_applied
);

    localparam int PW = CW + 17;

    logic [QW-1:0] r_prev, r_top, r_th, n_th;
    logic [CW-1:0] r_tp, r_best_tp, r_best_p, r_nx;
    logic          r_fin1, r_fin2, r_valid, r_floored;
    logic [QW-1:0] r_o_th;
    logic [CW-1:0] r_o_tp, r_o_p, r_o_r;

    logic          e_en, e_better;
    logic [CW-1:0] e_nx;
    logic [QW-1:0] e_cand;
    logic [QW:0]   w_sum;
    logic [QW-1:0] w_mid, w_dec, w_inc, w_th0;
    logic [2*CW+1:0] w_lhs, w_rhs;
    logic [PW-1:0] w_flhs, w_frhs;
    logic          w_low;

    assign w_sum = {i_item.score[QW-1], i_item.score} + {r_prev[QW-1], r_prev};
    assign w_mid = w_sum[QW:1];
    assign w_dec = (r_prev == Q_MIN) ? r_prev : r_prev - 1'b1;
    assign w_inc = (i_item.score == Q_MAX) ? i_item.score : i_item.score + 1'b1;
    assign w_th0 = ($signed(i_def_thr) > $signed(w_inc)) ? i_def_thr : w_inc;

    // one cut evaluation per cycle: group boundary while streaming, final cut after
    always_comb begin
        e_en   = 1'b0;
        e_nx   = i_idx;
        e_cand = w_mid;
        if (r_fin1) begin
            e_en   = 1'b1;
            e_nx   = r_nx;
            e_cand = w_dec;
        end else if (i_step.vld && !i_step.first && i_item.score != r_prev) begin
            e_en = 1'b1;
        end
    end

    assign w_lhs = (2*CW+2)'(r_tp) * (2*CW+2)'({1'b0, r_best_p} + {1'b0, i_pos});
    assign w_rhs = (2*CW+2)'(r_best_tp) * (2*CW+2)'({1'b0, e_nx} + {1'b0, i_pos});
    assign e_better = e_en && (r_tp != '0) && (w_lhs > w_rhs);
    assign n_th = e_better ? e_cand : r_th;

    assign w_flhs = PW'(r_best_tp) << 17;
    assign w_frhs = PW'(i_floor_ratio) * PW'({1'b0, r_best_p} + {1'b0, i_pos});
    assign w_low  = (r_best_tp == '0) ? (i_floor_ratio != '0) : (w_flhs < w_frhs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin1  <= 1'b0;
            r_fin2  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_fin1  <= i_step.vld && i_step.last;
            r_fin2  <= r_fin1;
            r_valid <= r_fin2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_better) begin
            r_best_tp <= r_tp;
            r_best_p  <= e_nx;
        end
        r_th <= n_th;
        if (i_step.vld) begin
            r_prev <= i_item.score;
            if (i_step.first) begin
                r_top     <= i_item.score;
                r_th      <= w_th0;
                r_tp      <= CW'(i_item.label);
                r_best_tp <= '0;
                r_best_p  <= '0;
            end else begin
                r_tp <= r_tp + CW'(i_item.label);
            end
            r_nx <= i_idx + 1'b1;
        end
        if (r_fin2) begin
            r_floored <= i_floor_en && w_low;
            r_o_th    <= (i_floor_en && w_low) ? r_top : r_th;
            r_o_tp    <= r_best_tp;
            r_o_p     <= r_best_p;
            r_o_r     <= i_pos;
        end
    end

    assign o_valid         = r_valid;
    assign o_threshold     = r_o_th;
    assign o_best_true_pos = OUT_CW'(r_o_tp);
    assign o_best_pred_pos = OUT_CW'(r_o_p);
    assign o_actual_pos    = OUT_CW'(r_o_r);
    assign o_floor_applied = r_floored;

endmodule

// File: rtl/f1_optimal_threshold_search_top.sv
// Load: one beat per cycle, busy stays low until a beat with last is taken.
// After last: the sorting chain settles in the drain phase, the sweep reads the
// set out of the chain head, and the result passes fin1, fin2 and valid to the strobe.
// One set is searched at a time; busy rises once last is taken and falls after the strobe cycle.
// Synchronous active-low reset empties the chain, clears counts, restores config.
module f1_optimal_threshold_search_top
    import ots_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [QW-1:0]        i_score,
    input  logic                 i_label,
    input  logic                 i_last,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [QW-1:0]        i_cfg_data,
    output logic                 o_valid,
    output logic [QW-1:0]        o_threshold,
    output logic [OUT_CW-1:0]    o_best_true_pos,
    output logic [OUT_CW-1:0]    o_best_pred_pos,
    output logic [OUT_CW-1:0]    o_actual_pos,
    output logic                 o_floor_applied
);

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

    localparam logic [1:0] S_LOAD  = 2'd0;
    localparam logic [1:0] S_DRAIN = 2'd1;
    localparam logic [1:0] S_SWEEP = 2'd2;
    localparam logic [1:0] S_FINAL = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [CW-1:0]      r_cnt, n_cnt, r_pos, n_pos, r_tmr, n_tmr;
    logic [QW-1:0]      r_def_thr;
    logic               r_floor_en;
    logic [RATIO_W-1:0] r_floor_ratio;

    logic  w_acc, w_shift;
    t_item w_new;
    t_step w_step;
    t_item c_pass [MAX_ITEMS];
    t_item c_held [MAX_ITEMS];

    assign o_busy  = (r_state != S_LOAD);
    assign w_acc   = i_start && !o_busy;
    assign w_shift = (r_state == S_SWEEP);
    assign w_new   = '{vld: w_acc && (r_cnt < MAX_CNT), score: i_score, label: i_label};

    genvar g;
    generate
        for (g = 0; g < MAX_ITEMS; g++) begin : g_cell
            ots_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_in    ((g == 0) ? w_new : c_pass[(g == 0) ? 0 : g - 1]),
                .i_right ((g == MAX_ITEMS - 1) ? t_item'('0)
                                               : c_held[(g == MAX_ITEMS - 1) ? g : g + 1]),
                .o_pass  (c_pass[g]),
                .o_held  (c_held[g])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_pos   = r_pos;
        n_tmr   = r_tmr;
        case (r_state)
            S_LOAD: begin
                if (w_acc) begin
                    if (r_cnt < MAX_CNT) begin
                        n_cnt = r_cnt + 1'b1;
                        n_pos = r_pos + CW'(i_label);
                    end
                    if (i_last) begin
                        n_state = S_DRAIN;
                        n_tmr   = '0;
                    end
                end
            end
            S_DRAIN: begin
                n_tmr = r_tmr + 1'b1;
                if (r_tmr == r_cnt) begin
                    n_state = S_SWEEP;
                    n_tmr   = '0;
                end
            end
            S_SWEEP: begin
                n_tmr = r_tmr + 1'b1;
                if (r_tmr == r_cnt - 1'b1) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                if (o_valid) begin
                    n_state = S_LOAD;
                    n_cnt   = '0;
                    n_pos   = '0;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_LOAD;
            r_cnt         <= '0;
            r_pos         <= '0;
            r_tmr         <= '0;
            r_def_thr     <= DEF_THR_RST;
            r_floor_en    <= 1'b0;
            r_floor_ratio <= FLOOR_RATIO_RST;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pos   <= n_pos;
            r_tmr   <= n_tmr;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DEF_THR:     r_def_thr     <= i_cfg_data;
                    CFG_FLOOR_EN:    r_floor_en    <= i_cfg_data[0];
                    CFG_FLOOR_RATIO: r_floor_ratio <= i_cfg_data[RATIO_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign w_step = '{vld:   w_shift,
                      first: w_shift && (r_tmr == '0),
                      last:  w_shift && (r_tmr == r_cnt - 1'b1)};

    ots_sweep #(
        .CW (CW)
    ) u_sweep (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_step),
        .i_item          (c_held[0]),
        .i_idx           (r_tmr),
        .i_pos           (r_pos),
        .i_def_thr       (r_def_thr),
        .i_floor_en      (r_floor_en),
        .i_floor_ratio   (r_floor_ratio),
        .o_valid         (o_valid),
        .o_threshold     (o_threshold),
        .o_best_true_pos (o_best_true_pos),
        .o_best_pred_pos (o_best_pred_pos),
        .o_actual_pos    (o_actual_pos),
        .o_floor_applied (o_floor_applied)
    );

    a_strobe_in_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == S_FINAL)
        else $error("result strobe outside final phase");

    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SWEEP |-> c_held[0].vld)
        else $error("sweep read an empty chain head");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAX_CNT && r_pos <= r_cnt)
        else $error("item or positive count out of range");

    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_busy && r_cnt == '0)
        else $error("set not released after result");

endmodule
